// File: sv/spn_pkg.sv
// Shared types and constants for the power spectrum normalizer.
`default_nettype none
package spn_pkg;

	localparam int JOB_CNT_W = 7;
	localparam int IDX_W     = 2;
	localparam int CFG_W     = 3;

	localparam logic CFG_N_COUNT = 1'b0;
	localparam logic CFG_L_COUNT = 1'b1;

	localparam logic [15:0] Q_ONE = 16'd16384;

	typedef struct packed {
		logic [JOB_CNT_W-1:0] count;
		logic [IDX_W-1:0]     n_last;
		logic [IDX_W-1:0]     l_last;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_SQ,
		ST_SUM,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_FETCH,
		ST_LOAD,
		ST_DIV,
		ST_OUT
	} eng_state_t;

endpackage
`default_nettype wire

// File: sv/soap_power_spectrum_normalize_core.sv
// Top level of the normalized power spectrum core.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | coef_real, coef_imag, last_coef
//   out      | out_valid/out_stall| norm_value, first_radial, second_radial,
//            |                    | degree, zero_norm, last_value
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// Coefficients load one per cycle while in_stall is low. After the last one
// the engine sums each (n1,n2,l) power value over 2L-1 slots, takes a square
// root, then divides each result (skipped when the norm is zero) for output.
// in_stall is high from the last coefficient until the final result is taken.
// Reset clears control state and sets both counts to 4; the stores need none.
`default_nettype none
module soap_power_spectrum_normalize_core #(
	parameter int N_MAX = 4,
	parameter int L_MAX = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [2:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [11:0] coef_real,
	input  wire logic signed [11:0] coef_imag,
	input  wire logic              last_coef,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [15:0]     norm_value,
	output logic [1:0]             first_radial,
	output logic [1:0]             second_radial,
	output logic [1:0]             degree,
	output logic                   zero_norm,
	output logic                   last_value
);

	localparam int AW = $clog2(N_MAX * L_MAX * (2 * L_MAX - 1));

	logic               busy, job_push, job_pop, q_empty;
	spn_pkg::job_t      push_job, head_job;
	logic [AW-1:0]      addr_a, addr_b;
	logic signed [11:0] real_a, imag_a, real_b, imag_b;

	spn_front #(.N_MAX(N_MAX), .L_MAX(L_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coef_real (coef_real),
		.coef_imag (coef_imag),
		.last_coef (last_coef),
		.busy      (busy),
		.job_push  (job_push),
		.job       (push_job),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.real_a    (real_a),
		.imag_a    (imag_a),
		.real_b    (real_b),
		.imag_b    (imag_b)
	);

	spn_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	spn_engine #(.N_MAX(N_MAX), .L_MAX(L_MAX)) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_ready     (!q_empty),
		.job           (head_job),
		.job_pop       (job_pop),
		.busy          (busy),
		.addr_a        (addr_a),
		.addr_b        (addr_b),
		.real_a        (real_a),
		.imag_a        (imag_a),
		.real_b        (real_b),
		.imag_b        (imag_b),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.norm_value    (norm_value),
		.first_radial  (first_radial),
		.second_radial (second_radial),
		.degree        (degree),
		.zero_norm     (zero_norm),
		.last_value    (last_value)
	);

endmodule
`default_nettype wire

// File: sv/spn_front.sv
// Front end: configuration, coefficient store and job issue.
`default_nettype none
module spn_front #(
	parameter int N_MAX = 4,
	parameter int L_MAX = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [spn_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [11:0]       coef_real,
	input  wire logic signed [11:0]       coef_imag,
	input  wire logic                     last_coef,
	input  wire logic                     busy,
	output logic                          job_push,
	output spn_pkg::job_t                 job,
	input  wire logic [$clog2(N_MAX*L_MAX*(2*L_MAX-1))-1:0] addr_a,
	input  wire logic [$clog2(N_MAX*L_MAX*(2*L_MAX-1))-1:0] addr_b,
	output logic signed [11:0]            real_a,
	output logic signed [11:0]            imag_a,
	output logic signed [11:0]            real_b,
	output logic signed [11:0]            imag_b
);

	localparam int SD = N_MAX * L_MAX * (2 * L_MAX - 1);
	localparam int AW = $clog2(SD);
	localparam int CW = $clog2(SD + 1);
	localparam int NW = (N_MAX > 1) ? $clog2(N_MAX) : 1;
	localparam int LW = (L_MAX > 1) ? $clog2(L_MAX) : 1;

	logic [spn_pkg::CFG_W-1:0] nreg_q, lreg_q;
	logic [CW-1:0]             load_q;
	logic signed [11:0]        real_mem [SD];
	logic signed [11:0]        imag_mem [SD];

	logic [CW-1:0] nc, lc, total, next_cnt;
	logic          accept, store_en;

	always_comb begin
		if (nreg_q == '0) begin
			nc = CW'(1);
		end else if (CW'(nreg_q) > CW'(N_MAX)) begin
			nc = CW'(N_MAX);
		end else begin
			nc = CW'(nreg_q);
		end
		if (lreg_q == '0) begin
			lc = CW'(1);
		end else if (CW'(lreg_q) > CW'(L_MAX)) begin
			lc = CW'(L_MAX);
		end else begin
			lc = CW'(lreg_q);
		end
		total    = CW'(CW'(nc * lc) * CW'(2 * lc - CW'(1)));
		accept   = in_valid && !in_stall;
		store_en = accept && (load_q < total);
		next_cnt = store_en ? CW'(load_q + CW'(1)) : load_q;
	end

	assign in_stall = busy;
	assign job_push = accept && last_coef;

	always_comb begin
		job        = '0;
		job.count  = spn_pkg::JOB_CNT_W'(next_cnt);
		job.n_last = spn_pkg::IDX_W'(NW'(nc - CW'(1)));
		job.l_last = spn_pkg::IDX_W'(LW'(lc - CW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nreg_q <= spn_pkg::CFG_W'(4);
			lreg_q <= spn_pkg::CFG_W'(4);
			load_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == spn_pkg::CFG_N_COUNT) begin
					nreg_q <= cfg_data;
				end else begin
					lreg_q <= cfg_data;
				end
				load_q <= '0;
			end else if (accept) begin
				load_q <= last_coef ? '0 : next_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			real_mem[load_q[AW-1:0]] <= coef_real;
			imag_mem[load_q[AW-1:0]] <= coef_imag;
		end
		real_a <= real_mem[addr_a];
		imag_a <= imag_mem[addr_a];
		real_b <= real_mem[addr_b];
		imag_b <= imag_mem[addr_b];
	end

endmodule
`default_nettype wire

// File: sv/spn_queue.sv
// Two-entry job queue between front end and engine.
`default_nettype none
module spn_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spn_pkg::job_t push_job,
	input  wire logic          pop,
	output logic               empty,
	output spn_pkg::job_t      head
);

	spn_pkg::job_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    fill_q;

	assign empty = (fill_q == 2'd0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

endmodule
`default_nettype wire

// File: sv/spn_engine.sv
// Back end: power sums, square root, normalizing divide and result output.
`default_nettype none
module spn_engine #(
	parameter int N_MAX = 4,
	parameter int L_MAX = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_ready,
	input  wire spn_pkg::job_t job,
	output logic               job_pop,
	output logic               busy,
	output logic [$clog2(N_MAX*L_MAX*(2*L_MAX-1))-1:0] addr_a,
	output logic [$clog2(N_MAX*L_MAX*(2*L_MAX-1))-1:0] addr_b,
	input  wire logic signed [11:0] real_a,
	input  wire logic signed [11:0] imag_a,
	input  wire logic signed [11:0] real_b,
	input  wire logic signed [11:0] imag_b,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [15:0] norm_value,
	output logic [1:0]         first_radial,
	output logic [1:0]         second_radial,
	output logic [1:0]         degree,
	output logic               zero_norm,
	output logic               last_value
);

	localparam int SD = N_MAX * L_MAX * (2 * L_MAX - 1);
	localparam int AW = $clog2(SD);
	localparam int CW = $clog2(SD + 1);
	localparam int NW = (N_MAX > 1) ? $clog2(N_MAX) : 1;
	localparam int LW = (L_MAX > 1) ? $clog2(L_MAX) : 1;
	localparam int SW = (L_MAX > 1) ? $clog2(2 * L_MAX - 1) : 1;
	localparam int PW = 2 * NW + LW;
	localparam int PD = 1 << PW;

	spn_pkg::eng_state_t st_q, st_d;

	logic [NW-1:0] nl_q, n1_q, n2_q;
	logic [LW-1:0] ll_q, l_q;
	logic [SW-1:0] s_q;
	logic [CW-1:0] cnt_q;
	logic          vld_s1;
	logic signed [24:0] prod_q;
	logic signed [27:0] acc_q;
	logic [53:0]   sq_q;
	logic [61:0]   sum_q;
	logic [61:0]   rem_q;
	logic [62:0]   res_q, bit_q;
	logic [30:0]   norm_q;
	logic signed [27:0] pw_rd_q;
	logic signed [27:0] pw_mem [PD];
	logic [47:0]   num_q, dsh_q;
	logic [15:0]   quo_q;
	logic [3:0]    dcnt_q;
	logic          neg_q;

	logic [CW-1:0] lc, slots, a1, a2;
	logic [PW-1:0] pidx;
	logic          slot_ok, last_s, last_l, last_n2, last_n1, all_done;
	logic signed [23:0] rr, ii;
	logic [26:0]   acc_mag, pw_mag;
	logic [62:0]   root_t;
	logic          root_ge, div_ge;
	logic [15:0]   qcap;

	always_comb begin
		lc      = CW'(ll_q) + CW'(1);
		slots   = CW'(CW'(2) * CW'(ll_q) + CW'(1));
		a1      = CW'(CW'(CW'(n1_q) * lc + CW'(l_q)) * slots + CW'(s_q));
		a2      = CW'(CW'(CW'(n2_q) * lc + CW'(l_q)) * slots + CW'(s_q));
		slot_ok = (a1 < cnt_q) && (a2 < cnt_q)
			&& (CW'(s_q) + CW'(l_q) >= CW'(ll_q))
			&& (CW'(s_q) <= CW'(ll_q) + CW'(l_q));
		last_s  = (CW'(s_q) == slots - CW'(1));
		last_l  = (l_q == ll_q);
		last_n2 = (n2_q == nl_q);
		last_n1 = (n1_q == nl_q);
		all_done = last_l && last_n2 && last_n1;
		pidx    = {n1_q, n2_q, l_q};
		rr      = real_a * real_b;
		ii      = imag_a * imag_b;
		acc_mag = acc_q[27] ? 27'(-acc_q) : acc_q[26:0];
		pw_mag  = pw_rd_q[27] ? 27'(-pw_rd_q) : pw_rd_q[26:0];
		root_t  = res_q + bit_q;
		root_ge = {1'b0, rem_q} >= root_t;
		div_ge  = num_q >= dsh_q;
		qcap    = (quo_q > spn_pkg::Q_ONE) ? spn_pkg::Q_ONE : quo_q;
	end

	assign addr_a = a1[AW-1:0];
	assign addr_b = a2[AW-1:0];

	always_comb begin
		st_d = st_q;
		case (st_q)
			spn_pkg::ST_IDLE:      if (job_ready) st_d = spn_pkg::ST_RD;
			spn_pkg::ST_RD:        st_d = spn_pkg::ST_MUL;
			spn_pkg::ST_MUL:       st_d = spn_pkg::ST_ACC;
			spn_pkg::ST_ACC:       st_d = last_s ? spn_pkg::ST_SQ : spn_pkg::ST_RD;
			spn_pkg::ST_SQ:        st_d = spn_pkg::ST_SUM;
			spn_pkg::ST_SUM:       st_d = all_done ? spn_pkg::ST_ROOT_INIT : spn_pkg::ST_RD;
			spn_pkg::ST_ROOT_INIT: st_d = spn_pkg::ST_ROOT;
			spn_pkg::ST_ROOT:      if (bit_q == '0) st_d = spn_pkg::ST_FETCH;
			spn_pkg::ST_FETCH:     st_d = spn_pkg::ST_LOAD;
			spn_pkg::ST_LOAD:      st_d = (norm_q == '0) ? spn_pkg::ST_OUT : spn_pkg::ST_DIV;
			spn_pkg::ST_DIV:       if (dcnt_q == 4'd15) st_d = spn_pkg::ST_OUT;
			spn_pkg::ST_OUT: begin
				if (!out_stall) begin
					st_d = all_done ? spn_pkg::ST_IDLE : spn_pkg::ST_FETCH;
				end
			end
			default:               st_d = spn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = (st_q == spn_pkg::ST_IDLE) && job_ready;
		busy      = (st_q != spn_pkg::ST_IDLE) || job_ready;
		out_valid = (st_q == spn_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= spn_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			spn_pkg::ST_IDLE: begin
				nl_q  <= job.n_last[NW-1:0];
				ll_q  <= job.l_last[LW-1:0];
				cnt_q <= CW'(job.count);
				n1_q  <= '0;
				n2_q  <= '0;
				l_q   <= '0;
				s_q   <= '0;
				acc_q <= '0;
				sum_q <= '0;
			end
			spn_pkg::ST_RD: vld_s1 <= slot_ok;
			spn_pkg::ST_MUL: prod_q <= vld_s1 ? 25'(rr) + 25'(ii) : '0;
			spn_pkg::ST_ACC: begin
				acc_q <= acc_q + 28'(prod_q);
				if (!last_s) begin
					s_q <= s_q + SW'(1);
				end
			end
			spn_pkg::ST_SQ: begin
				pw_mem[pidx] <= acc_q;
				sq_q         <= acc_mag * acc_mag;
			end
			spn_pkg::ST_SUM: begin
				sum_q <= sum_q + 62'(sq_q);
				acc_q <= '0;
				s_q   <= '0;
				if (!all_done) begin
					if (!last_l) begin
						l_q <= l_q + LW'(1);
					end else begin
						l_q <= '0;
						if (!last_n2) begin
							n2_q <= n2_q + NW'(1);
						end else begin
							n2_q <= '0;
							n1_q <= n1_q + NW'(1);
						end
					end
				end
			end
			spn_pkg::ST_ROOT_INIT: begin
				rem_q <= sum_q;
				res_q <= '0;
				bit_q <= 63'(1) << 62;
				n1_q  <= '0;
				n2_q  <= '0;
				l_q   <= '0;
			end
			spn_pkg::ST_ROOT: begin
				if (bit_q == '0) begin
					norm_q <= res_q[30:0];
				end else begin
					if (root_ge) begin
						rem_q <= rem_q - root_t[61:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			spn_pkg::ST_FETCH: pw_rd_q <= pw_mem[pidx];
			spn_pkg::ST_LOAD: begin
				num_q  <= (48'(pw_mag) << 15) + 48'(norm_q);
				dsh_q  <= 48'(norm_q) << 16;
				quo_q  <= '0;
				dcnt_q <= '0;
				neg_q  <= pw_rd_q[27] && (norm_q != '0);
			end
			spn_pkg::ST_DIV: begin
				if (div_ge) begin
					num_q <= num_q - dsh_q;
				end
				quo_q  <= {quo_q[14:0], div_ge};
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q + 4'd1;
			end
			spn_pkg::ST_OUT: begin
				if (!out_stall && !all_done) begin
					if (!last_l) begin
						l_q <= l_q + LW'(1);
					end else begin
						l_q <= '0;
						if (!last_n2) begin
							n2_q <= n2_q + NW'(1);
						end else begin
							n2_q <= '0;
							n1_q <= n1_q + NW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign norm_value    = neg_q ? -$signed(qcap) : $signed(qcap);
	assign first_radial  = 2'(n1_q);
	assign second_radial = 2'(n2_q);
	assign degree        = 2'(l_q);
	assign zero_norm     = (norm_q == '0);
	assign last_value    = all_done;

endmodule
`default_nettype wire
